### rtl/khs_pkg.sv
// shared types, constants and the byte-wide crc step for the key hash slot block
package khs_pkg;

	localparam int unsigned KeyByteW  = 8;
	localparam int unsigned CrcW      = 16;
	localparam int unsigned SlotW     = 14;
	localparam int unsigned OutDataW  = 16;

	localparam logic [CrcW-1:0]     CrcPoly    = 16'h1021;
	localparam logic [CrcW-1:0]     CrcTopBit  = 16'h8000;
	localparam logic [KeyByteW-1:0] OpenBrace  = 8'h7B;
	localparam logic [KeyByteW-1:0] CloseBrace = 8'h7D;

	typedef enum logic [1:0] {
		PH_SEEK   = 2'd0,
		PH_INSIDE = 2'd1,
		PH_CLOSED = 2'd2
	} phase_t;

	typedef struct packed {
		logic [KeyByteW-1:0] key_byte;
		logic                last_byte;
	} item_t;

	typedef struct packed {
		logic [SlotW-1:0] slot;
		logic             used_tag;
	} result_t;

	// crc-16, msb first, one byte unrolled into eight shift steps
	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
			input logic [KeyByteW-1:0] b);
		logic [CrcW-1:0] c;
		c = crc ^ {b, {(CrcW-KeyByteW){1'b0}}};
		for (int k = 0; k < KeyByteW; k++) begin
			if ((c & CrcTopBit) != '0) begin
				c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[CrcW-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/khs_in_stage.sv
// input register stage holding one key byte request
module khs_in_stage
	import khs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	// stage is free when empty or when its request moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/khs_hash.sv
// running whole-key and hash-tag crc state with slot selection on the last byte
module khs_hash
	import khs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item_s1,
	output logic    result_valid,
	output result_t result
);

	logic [CrcW-1:0] whole_crc_q;
	logic [CrcW-1:0] tag_crc_q;
	phase_t          phase_q;
	logic            nonempty_q;

	logic [CrcW-1:0] whole_next;
	logic [CrcW-1:0] tag_next;
	phase_t          phase_next;
	logic            nonempty_next;
	logic            use_tag;

	always_comb begin
		whole_next    = crc_byte(whole_crc_q, item_s1.key_byte);
		tag_next      = tag_crc_q;
		phase_next    = phase_q;
		nonempty_next = nonempty_q;
		unique case (phase_q)
			PH_SEEK: begin
				if (item_s1.key_byte == OpenBrace) begin
					phase_next = PH_INSIDE;
				end
			end
			PH_INSIDE: begin
				if (item_s1.key_byte == CloseBrace) begin
					phase_next = PH_CLOSED;
				end else begin
					tag_next      = crc_byte(tag_crc_q, item_s1.key_byte);
					nonempty_next = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign use_tag         = (phase_next == PH_CLOSED) && nonempty_next;
	assign result_valid    = advance && item_s1.last_byte;
	assign result.used_tag = use_tag;
	assign result.slot     = use_tag ? tag_next[SlotW-1:0] : whole_next[SlotW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_crc_q <= '0;
			tag_crc_q   <= '0;
			phase_q     <= PH_SEEK;
			nonempty_q  <= 1'b0;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				// key done, start over for the next one
				whole_crc_q <= '0;
				tag_crc_q   <= '0;
				phase_q     <= PH_SEEK;
				nonempty_q  <= 1'b0;
			end else begin
				whole_crc_q <= whole_next;
				tag_crc_q   <= tag_next;
				phase_q     <= phase_next;
				nonempty_q  <= nonempty_next;
			end
		end
	end

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> (phase_q == PH_SEEK) && (whole_crc_q == '0) && !nonempty_q)
		else $error("crc state not cleared after last byte");

	a_nonempty_needs_brace: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> (phase_q != PH_SEEK))
		else $error("tag marked nonempty before an opening brace");

	a_tag_crc_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_crc_q != '0) |-> nonempty_q)
		else $error("tag crc moved without a tag byte");

endmodule

### rtl/khs_out_stage.sv
// result register toward the output stream
module khs_out_stage
	import khs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result_q
);

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			result_q <= result;
		end
	end

endmodule

### rtl/key_hash_slot_crc16_top.sv
// Key hash slot unit. A key streams in one byte per request, in order, with tlast on its
// final byte; one result comes out per key, carrying the 14-bit slot (crc-16 poly 0x1021,
// init 0, msb first, modulo 16384) and a flag telling whether the crc covered the hash
// tag between the first '{' and the next '}' or the whole key. A new byte is taken every
// cycle: each byte passes an input register and one byte-wide crc step into the result
// register, and a result becomes valid there once its last byte leaves the input register.
// Intake stalls only while a finished result waits on m_axis_tready and the next last
// byte needs the result register.
module key_hash_slot_crc16_top
	import khs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [KeyByteW-1:0] s_axis_tdata,  // [7:0] key_byte
	input  logic                s_axis_tlast,  // last_byte
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,  // [13:0] slot, [15:14] zero
	output logic                m_axis_tuser   // used_tag
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    out_free;
	logic    result_valid;
	result_t result;
	result_t result_q;

	assign in_item.key_byte  = s_axis_tdata;
	assign in_item.last_byte = s_axis_tlast;

	// a byte that ends a key needs room in the result register
	assign advance = valid_s1 && (!item_s1.last_byte || out_free);

	khs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	khs_hash u_hash (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item_s1      (item_s1),
		.result_valid (result_valid),
		.result       (result)
	);

	khs_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (result_valid),
		.result    (result),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result_q  (result_q)
	);

	assign m_axis_tdata = {{(OutDataW-SlotW){1'b0}}, result_q.slot};
	assign m_axis_tuser = result_q.used_tag;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> m_axis_tvalid)
		else $error("last byte advanced without a result");

	a_no_advance_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.last_byte && m_axis_tvalid && !m_axis_tready) |-> !advance)
		else $error("last byte advanced over a waiting result");

endmodule
